FILE: src/cpu8mx_pkg.sv
// Shared constants for the 8-bit micro-op executor: operation codes,
// fixed register indexes and status flag bit positions.
// No dependencies.
package cpu8mx_pkg;

  localparam int REG_COUNT_DEF = 16;

  // operation codes
  localparam logic [4:0] K_FETCH  = 5'd0;
  localparam logic [4:0] K_LOAD   = 5'd1;
  localparam logic [4:0] K_PCINC  = 5'd2;
  localparam logic [4:0] K_AD2    = 5'd3;
  localparam logic [4:0] K_AD2C   = 5'd4;
  localparam logic [4:0] K_ADD    = 5'd5;
  localparam logic [4:0] K_ADDC   = 5'd6;
  localparam logic [4:0] K_ADC    = 5'd7;
  localparam logic [4:0] K_BIT    = 5'd8;
  localparam logic [4:0] K_FTEST  = 5'd9;
  localparam logic [4:0] K_FNTEST = 5'd10;
  localparam logic [4:0] K_CMP    = 5'd11;
  localparam logic [4:0] K_INC    = 5'd12;
  localparam logic [4:0] K_DEC    = 5'd13;
  localparam logic [4:0] K_ASL    = 5'd14;
  localparam logic [4:0] K_LSR    = 5'd15;
  localparam logic [4:0] K_ROL    = 5'd16;
  localparam logic [4:0] K_ROR    = 5'd17;
  localparam logic [4:0] K_SET    = 5'd18;
  localparam logic [4:0] K_CLEAR  = 5'd19;
  localparam logic [4:0] K_SBC    = 5'd20;
  localparam logic [4:0] K_AND    = 5'd21;
  localparam logic [4:0] K_OR     = 5'd22;
  localparam logic [4:0] K_EOR    = 5'd23;
  localparam logic [4:0] K_NOP    = 5'd24;
  localparam logic [4:0] K_JAM    = 5'd25;

  // fixed register indexes
  localparam logic [3:0] RIX_SP  = 4'd3;
  localparam logic [3:0] RIX_PCL = 4'd4;
  localparam logic [3:0] RIX_PCH = 4'd5;
  localparam logic [3:0] RIX_ST  = 4'd6;

  // status bits
  localparam int FB_C = 0;
  localparam int FB_Z = 1;
  localparam int FB_D = 3;
  localparam int FB_V = 6;
  localparam int FB_N = 7;

endpackage

FILE: src/cpu8_microop_executor.sv
// 8-bit micro-op executor: input register, single-pass ALU, result register.
// Depends on cpu8mx_pkg.
//
// Usage:
// - Input channel (in_valid / in_stall) carries one micro-op per transaction:
//   kind, dest_reg, src_is_reg, src_value and four skip qualifiers.
// - Output channel (out_valid / out_stall) returns one result per micro-op:
//   executed flag, destination value, status, page-crossed and jam marks.
// - A taken micro-op waits in the input register; the ALU works from it
//   straight into the result register, which is loaded as the op advances.
// - Throughput: one micro-op per cycle unless out_stall holds a result. The
//   general register file is a memory whose two read ports are sampled as
//   the op enters the input register, with a bypass from the write that lands
//   on the same edge; PC and status live in flops and are read directly by the ALU.
// - When out_stall holds a result, the input register still takes one more
//   op, then in_stall rises until the result drains.
// - Synchronous reset clears the register file (valid bits), status, PC,
//   hidden carry and marks; the condition mark resets to true. in_stall is
//   high during reset; accepting resumes as soon as rst drops.
module cpu8_microop_executor #(
  parameter int REG_COUNT = cpu8mx_pkg::REG_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] kind,
  input  logic [3:0] dest_reg,
  input  logic       src_is_reg,
  input  logic [7:0] src_value,
  input  logic       only_if_cond,
  input  logic       only_if_not_cond,
  input  logic       only_if_crossed,
  input  logic       only_if_not_crossed,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       executed,
  output logic [7:0] dest_after,
  output logic [7:0] status_after,
  output logic       page_crossed,
  output logic       jammed
);

  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int DW    = (IDX_W > 4) ? IDX_W : 4;

  // architectural state
  logic [7:0]       mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;
  logic [7:0]       pcl, pch, st;
  logic             cond, crossed, jam;
  logic [1:0]       hc;

  // input register
  logic       s1_valid;
  logic [4:0] s1_kind;
  logic [3:0] s1_d;
  logic       s1_src_is_reg;
  logic [7:0] s1_sv;
  logic       s1_oc, s1_onc, s1_ocr, s1_oncr;
  logic [7:0] rd_a, rd_b;
  logic       rd_a_vld, rd_b_vld;

  logic in_take, advance;

  // read/write addressing
  logic [DW-1:0]    d_in_ext, d_s1_ext;
  logic [IDX_W-1:0] ia, ib, iw;
  logic             ia_ok, ib_ok, d_ok;
  logic             wr_en;
  logic [7:0]       wr_data;

  // ALU
  logic       skip, store;
  logic [7:0] a, b, b_reg, r;
  logic [7:0] st_n, pcl_n, pch_n, dest_n;
  logic       cond_n, crossed_n, jam_n;
  logic [1:0] hc_n;
  logic [15:0] pc_inc;
  logic signed [9:0] sum10, hc10;
  logic [4:0] dlo;
  logic [5:0] dhi;
  logic       lc, cout, bw;
  logic [8:0] sum9, bsub9;
  logic signed [5:0] sl, sh;
  logic [7:0] mask;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = rst || (s1_valid && !advance);
  assign in_take  = in_valid && !in_stall;

  assign d_in_ext = DW'(dest_reg);
  assign d_s1_ext = DW'(s1_d);
  assign ia    = d_in_ext[IDX_W-1:0];
  assign ib    = src_value[IDX_W-1:0];
  assign iw    = d_s1_ext[IDX_W-1:0];
  assign ia_ok = 32'(dest_reg) < REG_COUNT;
  assign ib_ok = 32'(src_value) < REG_COUNT;
  assign d_ok  = 32'(s1_d) < REG_COUNT;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_kind       <= kind;
      s1_d          <= dest_reg;
      s1_src_is_reg <= src_is_reg;
      s1_sv         <= src_value;
      s1_oc         <= only_if_cond;
      s1_onc        <= only_if_not_cond;
      s1_ocr        <= only_if_crossed;
      s1_oncr       <= only_if_not_crossed;
    end
  end

  // register file memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[iw] <= wr_data;
    end
    if (in_take) begin
      if (wr_en && iw == ia) begin
        rd_a     <= wr_data;
        rd_a_vld <= ia_ok;
      end else begin
        rd_a     <= mem[ia];
        rd_a_vld <= ia_ok && vld[ia];
      end
      if (wr_en && iw == ib) begin
        rd_b     <= wr_data;
        rd_b_vld <= ib_ok;
      end else begin
        rd_b     <= mem[ib];
        rd_b_vld <= ib_ok && vld[ib];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[iw] <= 1'b1;
    end
  end

  // operand selection: PC and status come from flops
  always_comb begin
    if (s1_d == cpu8mx_pkg::RIX_PCL) begin
      a = pcl;
    end else if (s1_d == cpu8mx_pkg::RIX_PCH) begin
      a = pch;
    end else if (s1_d == cpu8mx_pkg::RIX_ST) begin
      a = st;
    end else begin
      a = rd_a_vld ? rd_a : 8'h00;
    end
    if (s1_sv == {4'h0, cpu8mx_pkg::RIX_PCL}) begin
      b_reg = pcl;
    end else if (s1_sv == {4'h0, cpu8mx_pkg::RIX_PCH}) begin
      b_reg = pch;
    end else if (s1_sv == {4'h0, cpu8mx_pkg::RIX_ST}) begin
      b_reg = st;
    end else begin
      b_reg = rd_b_vld ? rd_b : 8'h00;
    end
    b = s1_src_is_reg ? b_reg : s1_sv;
  end

  always_comb begin
    skip = (s1_oc && !cond) || (s1_onc && cond) ||
           (s1_ocr && !crossed) || (s1_oncr && crossed);
    store     = 1'b0;
    r         = 8'h00;
    st_n      = st;
    pcl_n     = pcl;
    pch_n     = pch;
    cond_n    = cond;
    crossed_n = crossed;
    jam_n     = jam;
    hc_n      = hc;
    pc_inc    = {pch, pcl} + 16'd1;
    hc10      = {{8{hc[1]}}, hc};
    sum10     = '0;
    dlo       = '0;
    dhi       = '0;
    lc        = 1'b0;
    cout      = 1'b0;
    bw        = !st[cpu8mx_pkg::FB_C];
    sum9      = 9'({1'b0, a}) + 9'({1'b0, b}) + 9'({8'h00, st[cpu8mx_pkg::FB_C]});
    bsub9     = 9'({1'b0, b}) + 9'({8'h00, bw});
    sl        = '0;
    sh        = '0;
    mask      = (b[7:3] == 5'd0) ? (8'h01 << b[2:0]) : 8'h00;

    if (!skip) begin
      case (s1_kind)
        cpu8mx_pkg::K_LOAD: begin
          r = b;
          store = 1'b1;
          if (s1_d <= 4'd2) begin
            st_n[cpu8mx_pkg::FB_Z] = (r == 8'h00);
            st_n[cpu8mx_pkg::FB_N] = r[7];
          end
        end
        cpu8mx_pkg::K_PCINC: begin
          pcl_n     = pc_inc[7:0];
          pch_n     = pc_inc[15:8];
          crossed_n = (pc_inc[15:8] != pch);
        end
        cpu8mx_pkg::K_AD2, cpu8mx_pkg::K_AD2C: begin
          sum10 = $signed({2'b00, a}) + $signed({{2{b[7]}}, b}) +
                  ((s1_kind == cpu8mx_pkg::K_AD2C) ? hc10 : 10'sd0);
          crossed_n = (sum10 < 0) || (sum10 > 10'sd255);
          hc_n  = crossed_n ? (b[7] ? 2'b11 : 2'b01) : 2'b00;
          r     = sum10[7:0];
          store = 1'b1;
        end
        cpu8mx_pkg::K_ADD, cpu8mx_pkg::K_ADDC: begin
          sum10 = $signed({2'b00, a}) + $signed({2'b00, b}) +
                  ((s1_kind == cpu8mx_pkg::K_ADDC) ? hc10 : 10'sd0);
          crossed_n = (sum10 < 0) || (sum10 > 10'sd255);
          hc_n  = crossed_n ? 2'b01 : 2'b00;
          r     = sum10[7:0];
          store = 1'b1;
        end
        cpu8mx_pkg::K_ADC: begin
          if (st[cpu8mx_pkg::FB_D]) begin
            dlo = 5'({1'b0, a[3:0]}) + 5'({1'b0, b[3:0]}) +
                  5'({4'h0, st[cpu8mx_pkg::FB_C]});
            if (dlo > 5'd9) begin
              dlo = (dlo + 5'd6) & 5'h0F;
              lc  = 1'b1;
            end
            dhi = 6'({2'b00, a[7:4]}) + 6'({2'b00, b[7:4]}) + 6'({5'h00, lc});
            if (dhi > 6'd9) begin
              dhi = dhi + 6'd6;
            end
            cout = dhi > 6'd15;
            r    = {dhi[3:0], dlo[3:0]};
          end else begin
            cout = sum9[8];
            r    = sum9[7:0];
          end
          st_n[cpu8mx_pkg::FB_C] = cout;
          st_n[cpu8mx_pkg::FB_Z] = (r == 8'h00);
          st_n[cpu8mx_pkg::FB_N] = r[7];
          st_n[cpu8mx_pkg::FB_V] = !(a[7] ^ b[7]) && (a[7] ^ r[7]);
          store = 1'b1;
        end
        cpu8mx_pkg::K_BIT: begin
          st_n[cpu8mx_pkg::FB_Z] = ((a & b) == 8'h00);
          st_n[cpu8mx_pkg::FB_N] = b[7];
          st_n[cpu8mx_pkg::FB_V] = b[6];
        end
        cpu8mx_pkg::K_FTEST: begin
          cond_n = !s1_d[3] && st[s1_d[2:0]];
        end
        cpu8mx_pkg::K_FNTEST: begin
          cond_n = !(!s1_d[3] && st[s1_d[2:0]]);
        end
        cpu8mx_pkg::K_CMP: begin
          r = a - b;
          st_n[cpu8mx_pkg::FB_C] = (a >= b);
          st_n[cpu8mx_pkg::FB_Z] = (r == 8'h00);
          st_n[cpu8mx_pkg::FB_N] = r[7];
          r = 8'h00;
        end
        cpu8mx_pkg::K_INC, cpu8mx_pkg::K_DEC: begin
          r = (s1_kind == cpu8mx_pkg::K_INC) ? (a + 8'h01) : (a - 8'h01);
          store = 1'b1;
          if (s1_d != cpu8mx_pkg::RIX_SP) begin
            st_n[cpu8mx_pkg::FB_Z] = (r == 8'h00);
            st_n[cpu8mx_pkg::FB_N] = r[7];
          end
        end
        cpu8mx_pkg::K_ASL, cpu8mx_pkg::K_LSR,
        cpu8mx_pkg::K_ROL, cpu8mx_pkg::K_ROR: begin
          case (s1_kind)
            cpu8mx_pkg::K_ASL: r = {a[6:0], 1'b0};
            cpu8mx_pkg::K_LSR: r = {1'b0, a[7:1]};
            cpu8mx_pkg::K_ROL: r = {a[6:0], st[cpu8mx_pkg::FB_C]};
            default:           r = {st[cpu8mx_pkg::FB_C], a[7:1]};
          endcase
          st_n[cpu8mx_pkg::FB_C] = (s1_kind == cpu8mx_pkg::K_ASL ||
                                    s1_kind == cpu8mx_pkg::K_ROL) ? a[7] : a[0];
          st_n[cpu8mx_pkg::FB_Z] = (r == 8'h00);
          st_n[cpu8mx_pkg::FB_N] = r[7];
          store = 1'b1;
        end
        cpu8mx_pkg::K_SET: begin
          r = a | mask;
          store = 1'b1;
        end
        cpu8mx_pkg::K_CLEAR: begin
          r = a & ~mask;
          store = 1'b1;
        end
        cpu8mx_pkg::K_SBC: begin
          if (st[cpu8mx_pkg::FB_D]) begin
            sl = $signed({2'b00, a[3:0]}) - $signed({2'b00, b[3:0]}) -
                 $signed({5'b00000, bw});
            sh = $signed({2'b00, a[7:4]}) - $signed({2'b00, b[7:4]});
            if (sl < 0) begin
              sl = sl + 6'sd10;
              sh = sh - 6'sd1;
            end
            if (sh < 0) begin
              sh = sh + 6'sd10;
              st_n[cpu8mx_pkg::FB_C] = 1'b0;
            end else begin
              st_n[cpu8mx_pkg::FB_C] = 1'b1;
            end
            r = {sh[3:0], sl[3:0]};
          end else begin
            r = a - b - {7'h00, bw};
            st_n[cpu8mx_pkg::FB_C] = ({1'b0, a} >= bsub9);
          end
          st_n[cpu8mx_pkg::FB_Z] = (r == 8'h00);
          st_n[cpu8mx_pkg::FB_N] = r[7];
          st_n[cpu8mx_pkg::FB_V] = (a[7] ^ b[7]) && (a[7] ^ r[7]);
          store = 1'b1;
        end
        cpu8mx_pkg::K_AND, cpu8mx_pkg::K_OR, cpu8mx_pkg::K_EOR: begin
          case (s1_kind)
            cpu8mx_pkg::K_AND: r = a & b;
            cpu8mx_pkg::K_OR:  r = a | b;
            default:           r = a ^ b;
          endcase
          st_n[cpu8mx_pkg::FB_Z] = (r == 8'h00);
          st_n[cpu8mx_pkg::FB_N] = r[7];
          store = 1'b1;
        end
        cpu8mx_pkg::K_JAM: begin
          jam_n = 1'b1;
        end
        default: begin
        end
      endcase

      // result store wins over flag update when the destination is status
      if (store) begin
        if (s1_d == cpu8mx_pkg::RIX_ST) begin
          st_n = r;
        end else if (s1_d == cpu8mx_pkg::RIX_PCL) begin
          pcl_n = r;
        end else if (s1_d == cpu8mx_pkg::RIX_PCH) begin
          pch_n = r;
        end
      end
    end

    if (s1_d == cpu8mx_pkg::RIX_PCL) begin
      dest_n = pcl_n;
    end else if (s1_d == cpu8mx_pkg::RIX_PCH) begin
      dest_n = pch_n;
    end else if (s1_d == cpu8mx_pkg::RIX_ST) begin
      dest_n = st_n;
    end else if (store && !skip && d_ok) begin
      dest_n = r;
    end else begin
      dest_n = a;
    end
  end

  assign wr_en = advance && !skip && store && d_ok &&
                 s1_d != cpu8mx_pkg::RIX_PCL && s1_d != cpu8mx_pkg::RIX_PCH &&
                 s1_d != cpu8mx_pkg::RIX_ST;
  assign wr_data = r;

  // state and result register update on each advancing op
  always_ff @(posedge clk) begin
    if (rst) begin
      pcl       <= 8'h00;
      pch       <= 8'h00;
      st        <= 8'h00;
      cond      <= 1'b1;
      crossed   <= 1'b0;
      hc        <= 2'b00;
      jam       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        pcl       <= pcl_n;
        pch       <= pch_n;
        st        <= st_n;
        cond      <= cond_n;
        crossed   <= crossed_n;
        hc        <= hc_n;
        jam       <= jam_n;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      executed     <= !skip;
      dest_after   <= dest_n;
      status_after <= st_n;
      page_crossed <= crossed_n;
      jammed       <= jam_n;
    end
  end

`ifndef ASSERT_OFF
  a_jam_sticky: assert property (@(posedge clk) disable iff (rst) jam |=> jam)
    else $error("jam mark cleared without reset");

  a_hc_range: assert property (@(posedge clk) disable iff (rst) hc != 2'b10)
    else $error("hidden carry out of range");

  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status_after == st && page_crossed == crossed && jammed == jam))
    else $error("pending result disagrees with architectural state");

  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advancing op did not produce a result");

  a_skip_no_write: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && skip) |-> !wr_en)
    else $error("skipped op wrote the register file");
`endif

endmodule
